// ===== hw/rtl/best_fit_block_allocator_unit_macros.svh =====
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BFBA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFBA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bfba_pkg.sv =====
package bfba_pkg;

    localparam int BLOCKS_DEF    = 16;
    localparam int SIZE_BITS_DEF = 16;
    localparam int INDEX_W       = 4;
    localparam int FIELD_SIZE_W  = 16;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [INDEX_W-1:0]      block_index;
        logic [FIELD_SIZE_W-1:0] load_size;
        logic [FIELD_SIZE_W-1:0] request_size;
    } in_word_t;

    typedef struct packed {
        logic                    granted;
        logic [INDEX_W-1:0]      chosen_block;
        logic [FIELD_SIZE_W-1:0] leftover;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic begin_req;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } ctrl_stat_t;

endpackage

// ===== hw/rtl/bfba_datapath.sv =====
module bfba_datapath #(
    parameter int BLOCKS    = bfba_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = bfba_pkg::SIZE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfba_pkg::in_word_t    item,
    input  bfba_pkg::ctrl_cmd_t   cmd,
    output bfba_pkg::ctrl_stat_t  stat,
    output logic                  done,
    output bfba_pkg::out_word_t   result
);
    import bfba_pkg::*;

    localparam int IDX_W = $clog2(BLOCKS);

    logic [SIZE_BITS-1:0] size_mem [BLOCKS];
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_W-1:0]     ptr_next;
    logic                 cmp_vld_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SIZE_BITS-1:0] best_left_reg;
    logic [BLOCKS-1:0]    loaded_reg;
    logic [BLOCKS-1:0]    taken_reg;
    logic                 done_reg;
    out_word_t            res_reg;
    out_word_t            res_next;

    logic                 load_ok;
    logic [IDX_W-1:0]     widx;
    logic [SIZE_BITS-1:0] wsize;
    logic [SIZE_BITS:0]   diff;
    logic [SIZE_BITS-1:0] left;
    logic                 fits;
    logic                 better;

    assign load_ok = cmd.load && (32'(item.block_index) < 32'(BLOCKS));
    assign widx    = IDX_W'(item.block_index);
    assign wsize   = SIZE_BITS'(item.load_size);

    assign stat.scan_last = (ptr_reg == IDX_W'(BLOCKS - 1));
    assign ptr_next       = stat.scan_last ? '0 : ptr_reg + 1'b1;

    // one subtract-compare per scanned entry
    assign diff   = {1'b0, rd_data_reg} - {1'b0, req_reg};
    assign left   = diff[SIZE_BITS-1:0];
    assign fits   = cmp_vld_reg && loaded_reg[cmp_idx_reg] && !taken_reg[cmp_idx_reg]
                    && !diff[SIZE_BITS];
    assign better = fits && (!found_reg || (left < best_left_reg));

    always_comb
    begin
        res_next.granted      = found_reg;
        res_next.chosen_block = found_reg ? INDEX_W'(best_idx_reg) : '0;
        res_next.leftover     = found_reg ? FIELD_SIZE_W'(best_left_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            size_mem[widx] <= wsize;
        end
        rd_data_reg <= size_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_req)
        begin
            req_reg <= SIZE_BITS'(item.request_size);
        end
        cmp_idx_reg <= ptr_reg;
        if (better)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_left_reg <= left;
        end
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            loaded_reg  <= '0;
            taken_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan;
            done_reg    <= cmd.finish;
            if (cmd.begin_req)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    ptr_reg <= ptr_next;
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (load_ok)
            begin
                loaded_reg[widx] <= 1'b1;
                taken_reg[widx]  <= 1'b0;
            end
            if (cmd.finish && found_reg)
            begin
                taken_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hw/rtl/bfba_ctrl.sv =====
module bfba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  kind,
    input  bfba_pkg::ctrl_stat_t  stat,
    output logic                  busy,
    output bfba_pkg::ctrl_cmd_t   cmd
);
    import bfba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (kind == KIND_REQUEST))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = 1'b1;
        cmd.load      = 1'b0;
        cmd.begin_req = 1'b0;
        cmd.scan      = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.load      = start && (kind == KIND_LOAD);
                cmd.begin_req = start && (kind == KIND_REQUEST);
            end
            ST_SCAN:  cmd.scan   = 1'b1;
            ST_DRAIN: busy       = 1'b1;
            ST_DONE:  cmd.finish = 1'b1;
            default:  busy       = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/best_fit_block_allocator_unit.sv =====
// Best-fit allocator over a table of BLOCKS partition sizes. A word is taken
// when start is high and busy is low. A load word (kind 0) writes one entry in
// its accept cycle and gives no result; the next word may follow at once. A
// request word (kind 1) scans the size table one entry per cycle through the
// single read port of the table memory and one subtract-compare unit, then
// passes a drain state and a done state before the next word can be taken.
// Its result appears on result with done high for exactly one cycle, the
// cycle in which busy falls; there is no back-pressure, so it must be
// captured then.
module best_fit_block_allocator_unit #(
    parameter int BLOCKS    = bfba_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = bfba_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bfba_pkg::in_word_t  item,
    output logic                done,
    output bfba_pkg::out_word_t result
);
    import bfba_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    bfba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    bfba_datapath #(
        .BLOCKS    (BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

// ===== hw/rtl/bfba_checker.sv =====
`include "best_fit_block_allocator_unit_macros.svh"

module bfba_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input bfba_pkg::in_word_t  item,
    input logic                done,
    input bfba_pkg::out_word_t result
);
    import bfba_pkg::*;

    logic req_acc;
    logic load_acc;

    assign req_acc  = start && !busy && (item.kind == KIND_REQUEST);
    assign load_acc = start && !busy && (item.kind == KIND_LOAD);

    `BFBA_ASSERT_NXT(a_req_busy, clk, rst_n, req_acc, busy, "request did not raise busy")
    `BFBA_ASSERT_NXT(a_load_free, clk, rst_n, load_acc, !busy, "load held the unit busy")
    `BFBA_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done, "done held over two cycles")
    `BFBA_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "done while still busy")
    `BFBA_ASSERT_IMP(a_nofit_zero, clk, rst_n, done && !result.granted,
        (result.chosen_block == '0) && (result.leftover == '0), "no-fit word not zeroed")

endmodule

bind best_fit_block_allocator_unit bfba_checker u_bfba_checker (.*);

// ===== tb/tb_best_fit_block_allocator_unit.sv =====
module tb_best_fit_block_allocator_unit;
    import bfba_pkg::*;

    localparam int BLOCKS      = BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IN_W        = $bits(in_word_t);

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  item;
    logic      done;
    out_word_t result;

    logic [FIELD_SIZE_W-1:0] part_size [BLOCKS];
    logic                    part_loaded [BLOCKS];
    logic                    part_taken [BLOCKS];

    out_word_t grant_queue [$];
    out_word_t want;
    int        mismatch_count;
    int        cycle_count;
    int        sender_gap_pct;

    best_fit_block_allocator_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // model of the allocator, advanced on each accepted word
    task automatic allocate_best_fit(input in_word_t w);
        out_word_t r;
        logic      found;
        if (w.kind == KIND_LOAD)
        begin
            part_size[w.block_index]   = w.load_size;
            part_loaded[w.block_index] = 1'b1;
            part_taken[w.block_index]  = 1'b0;
        end
        else
        begin
            r     = '0;
            found = 1'b0;
            for (int k = 0; k < BLOCKS; k++)
            begin
                if (part_loaded[k] && !part_taken[k] && part_size[k] >= w.request_size)
                begin
                    if (!found || (part_size[k] - w.request_size) < r.leftover)
                    begin
                        found          = 1'b1;
                        r.granted      = 1'b1;
                        r.chosen_block = k[INDEX_W-1:0];
                        r.leftover     = part_size[k] - w.request_size;
                    end
                end
            end
            if (found)
                part_taken[r.chosen_block] = 1'b1;
            grant_queue.push_back(r);
        end
    endtask

    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            item  <= in_word_t'(IN_W'({$urandom, $urandom}));
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        allocate_best_fit(w);
    endtask

    function automatic in_word_t make_word(input logic kind, input int idx,
                                           input int bsize, input int rsize);
        in_word_t w;
        w.kind         = kind;
        w.block_index  = idx[INDEX_W-1:0];
        w.load_size    = bsize[FIELD_SIZE_W-1:0];
        w.request_size = rsize[FIELD_SIZE_W-1:0];
        return w;
    endfunction

    // mix of wide, tiny (ties), near-full and near-table sizes
    function automatic logic [FIELD_SIZE_W-1:0] pick_size();
        case ($urandom_range(3))
            0:       return FIELD_SIZE_W'($urandom);
            1:       return FIELD_SIZE_W'($urandom_range(0, 31));
            2:       return 16'hFFFF - FIELD_SIZE_W'($urandom_range(0, 3));
            default: return part_size[$urandom_range(BLOCKS-1)]
                            - FIELD_SIZE_W'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic test_empty_table();
        send_word(make_word(KIND_REQUEST, 0, 0, 0));
        send_word(make_word(KIND_REQUEST, 15, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_best_fit_rules();
        send_word(make_word(KIND_LOAD, 0, 16'hFFFF, 0));
        send_word(make_word(KIND_LOAD, 15, 0, 16'hFFFF));
        send_word(make_word(KIND_LOAD, 5, 100, 0));
        send_word(make_word(KIND_LOAD, 9, 100, 0));
        send_word(make_word(KIND_REQUEST, 0, 0, 0));
        send_word(make_word(KIND_REQUEST, 0, 0, 100));
        send_word(make_word(KIND_REQUEST, 0, 0, 100));
        send_word(make_word(KIND_REQUEST, 0, 0, 16'hFFFF));
        send_word(make_word(KIND_REQUEST, 0, 0, 1));
        // reload of a taken entry frees it
        send_word(make_word(KIND_LOAD, 5, 50, 0));
        send_word(make_word(KIND_REQUEST, 0, 0, 20));
        send_word(make_word(KIND_LOAD, 3, 16'hFFFF, 0));
        send_word(make_word(KIND_REQUEST, 0, 0, 0));
        send_word(make_word(KIND_LOAD, 7, 1000, 0));
        send_word(make_word(KIND_LOAD, 8, 999, 0));
        send_word(make_word(KIND_REQUEST, 0, 0, 998));
        send_word(make_word(KIND_REQUEST, 0, 0, 1001));
        send_word(make_word(KIND_REQUEST, 0, 0, 1000));
    endtask

    task automatic test_random_traffic(input int count, input int gap_pct);
        in_word_t w;
        sender_gap_pct = gap_pct;
        repeat (count)
        begin
            w.kind         = ($urandom_range(99) < 45) ? KIND_LOAD : KIND_REQUEST;
            w.block_index  = INDEX_W'($urandom);
            w.load_size    = pick_size();
            w.request_size = pick_size();
            send_word(w);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (grant_queue.size() == 0)
                flag_mismatch("result with nothing outstanding");
            else
            begin
                want = grant_queue.pop_front();
                if (result.granted !== want.granted)
                    flag_mismatch($sformatf("granted %b, want %b",
                                            result.granted, want.granted));
                if (result.chosen_block !== want.chosen_block)
                    flag_mismatch($sformatf("chosen_block %0d, want %0d",
                                            result.chosen_block, want.chosen_block));
                if (result.leftover !== want.leftover)
                    flag_mismatch($sformatf("leftover %0d, want %0d",
                                            result.leftover, want.leftover));
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        sender_gap_pct = 0;
        for (int k = 0; k < BLOCKS; k++)
        begin
            part_size[k]   = '0;
            part_loaded[k] = 1'b0;
            part_taken[k]  = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_best_fit_rules();
        test_random_traffic(300, 16);
        test_random_traffic(300, 81);
        test_random_traffic(300, 0);

        start <= 1'b0;
        while (grant_queue.size() != 0)
            @(posedge clk);
        repeat (2 * BLOCKS + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
